// File: hdl/md5_pkg.sv
// Shared types, constants and round tables for the MD5 digest block.
`default_nettype none

package md5_pkg;

  // Chaining word start values
  localparam logic [31:0] CHAIN_INIT_A = 32'h67452301;
  localparam logic [31:0] CHAIN_INIT_B = 32'hefcdab89;
  localparam logic [31:0] CHAIN_INIT_C = 32'h98badcfe;
  localparam logic [31:0] CHAIN_INIT_D = 32'h10325476;

  // Block layout
  localparam int BLOCK_BYTES = 64;
  localparam int POS_W       = $clog2(BLOCK_BYTES);
  localparam int WORDS       = BLOCK_BYTES / 4;
  localparam int WADDR_W     = $clog2(WORDS);
  localparam int ROUNDS      = 64;
  localparam int ROUND_W     = $clog2(ROUNDS);

  localparam logic [7:0]       PAD_MARK    = 8'h80;
  localparam logic [POS_W-1:0] PAD_LEN_POS = POS_W'(56);
  localparam logic [POS_W-1:0] LAST_POS    = POS_W'(BLOCK_BYTES - 1);
  localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);

  // Round groups, taken from the top two bits of the round number
  localparam logic [1:0] GRP_F = 2'd0;
  localparam logic [1:0] GRP_G = 2'd1;
  localparam logic [1:0] GRP_H = 2'd2;
  localparam logic [1:0] GRP_I = 2'd3;

  localparam logic [31:0] SINE_K [ROUNDS] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Rotate amounts, indexed by {group, round[1:0]}
  localparam logic [4:0] ROT_S [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT0,
    ST_EMIT1
  } md5_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic                 buf_we;
    logic [POS_W-1:0]     buf_addr;
    logic                 pad_sel;
    logic                 pad_mark;
    logic                 pad_len;
    logic [WADDR_W-1:0]   rd_addr;
    logic [ROUND_W-1:0]   round;
    logic                 work_load;
    logic                 round_en;
    logic                 fold;
    logic                 count_inc;
    logic                 chain_init;
    logic                 out_load;
    logic                 out_half;
  } md5_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             out_free;
  } md5_stat_t;

  // Message word used by a round
  function automatic logic [WADDR_W-1:0] msg_idx(input logic [ROUND_W-1:0] r);
    logic [7:0] r8;
    logic [7:0] v;
    r8 = {{(8-ROUND_W){1'b0}}, r};
    case (r[5:4])
      GRP_F:   v = r8;
      GRP_G:   v = 8'(8'd5 * r8 + 8'd1);
      GRP_H:   v = 8'(8'd3 * r8 + 8'd5);
      default: v = 8'(8'd7 * r8);
    endcase
    return v[WADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: hdl/md5_ctrl.sv
// Sequencer for byte intake, padding, compression rounds and digest output.
`default_nettype none

module md5_ctrl
  import md5_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic      last_byte,
  output      logic      in_ready,
  input  wire md5_stat_t stat,
  output      md5_cmd_t  cmd
);

  md5_state_t         state;
  md5_state_t         state_next;
  logic [ROUND_W-1:0] round;
  logic [POS_W-1:0]   ptr;
  logic [POS_W-1:0]   mark;
  logic               last_q;
  logic               pad_active;
  logic               second;
  logic               accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // State and sequencing counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      round      <= '0;
      ptr        <= '0;
      mark       <= '0;
      last_q     <= 1'b0;
      pad_active <= 1'b0;
      second     <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            last_q     <= last_byte;
            pad_active <= last_byte && (stat.pos != LAST_POS);
            second     <= 1'b0;
            ptr        <= POS_W'(stat.pos + 1'b1);
            mark       <= POS_W'(stat.pos + 1'b1);
          end
        end
        ST_LOAD: begin
          round <= '0;
        end
        ST_ROUND: begin
          round <= ROUND_W'(round + 1'b1);
        end
        ST_FOLD: begin
          if (last_q && !pad_active) begin
            // message ended on a block boundary: pad a fresh block
            ptr        <= '0;
            mark       <= '0;
            second     <= 1'b0;
            pad_active <= 1'b1;
          end else if (last_q && !second && (mark >= PAD_LEN_POS)) begin
            // length did not fit: one more block of zeros and length
            ptr    <= '0;
            second <= 1'b1;
          end
        end
        ST_PAD: begin
          ptr <= POS_W'(ptr + 1'b1);
        end
        ST_EMIT1: begin
          if (stat.out_free) begin
            last_q     <= 1'b0;
            pad_active <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (stat.pos == LAST_POS) begin
            state_next = ST_LOAD;
          end else if (last_byte) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_LOAD: begin
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        if (round == LAST_ROUND) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (!last_q) begin
          state_next = ST_IDLE;
        end else if (!pad_active) begin
          state_next = ST_PAD;
        end else if (!second && (mark >= PAD_LEN_POS)) begin
          state_next = ST_PAD;
        end else begin
          state_next = ST_EMIT0;
        end
      end
      ST_PAD: begin
        if (ptr == LAST_POS) begin
          state_next = ST_LOAD;
        end
      end
      ST_EMIT0: begin
        if (stat.out_free) begin
          state_next = ST_EMIT1;
        end
      end
      ST_EMIT1: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.buf_we    = accept;
        cmd.buf_addr  = stat.pos;
        cmd.count_inc = accept;
      end
      ST_LOAD: begin
        cmd.rd_addr   = msg_idx('0);
        cmd.work_load = 1'b1;
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        cmd.round    = round;
        cmd.rd_addr  = msg_idx(ROUND_W'(round + 1'b1));
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
      end
      ST_PAD: begin
        cmd.buf_we   = 1'b1;
        cmd.buf_addr = ptr;
        cmd.pad_sel  = 1'b1;
        cmd.pad_mark = !second && (ptr == mark);
        cmd.pad_len  = (second || (mark < PAD_LEN_POS)) && (ptr >= PAD_LEN_POS);
      end
      ST_EMIT0: begin
        cmd.out_load = stat.out_free;
        cmd.out_half = 1'b0;
      end
      ST_EMIT1: begin
        cmd.out_load   = stat.out_free;
        cmd.out_half   = 1'b1;
        cmd.chain_init = stat.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/md5_dp.sv
// Block store, bit counter, round logic, chaining words and output register.
`default_nettype none

module md5_dp
  import md5_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  data_byte,
  input  wire md5_cmd_t    cmd,
  output      md5_stat_t   stat,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [63:0] digest_half,
  output      logic        half_index,
  output      logic        digest_done
);

  logic [31:0] msg_mem [WORDS];
  logic [31:0] w_q;
  logic [63:0] bit_count;
  logic [31:0] chain_a, chain_b, chain_c, chain_d;
  logic [31:0] wa, wb, wc, wd;
  logic [7:0]  wr_byte;
  logic [7:0]  len_byte;
  logic [31:0] f_val;
  logic [31:0] t_sum;
  logic [63:0] t_rot;
  logic [4:0]  rot_s;
  logic [3:0]  rot_idx;

  assign stat.pos      = bit_count[POS_W+2:3];
  assign stat.out_free = !out_valid || out_ready;

  // Byte to store: message byte or padding
  assign len_byte = bit_count[{cmd.buf_addr[2:0], 3'b000} +: 8];
  always_comb begin
    if (!cmd.pad_sel) begin
      wr_byte = data_byte;
    end else if (cmd.pad_mark) begin
      wr_byte = PAD_MARK;
    end else if (cmd.pad_len) begin
      wr_byte = len_byte;
    end else begin
      wr_byte = 8'h00;
    end
  end

  // Block store: byte writes, registered word read
  always_ff @(posedge clk) begin
    if (cmd.buf_we) begin
      msg_mem[cmd.buf_addr[POS_W-1:2]][{cmd.buf_addr[1:0], 3'b000} +: 8] <= wr_byte;
    end
    w_q <= msg_mem[cmd.rd_addr];
  end

  // Message bit count
  always_ff @(posedge clk) begin
    if (rst || cmd.chain_init) begin
      bit_count <= '0;
    end else if (cmd.count_inc) begin
      bit_count <= bit_count + 64'd8;
    end
  end

  // Round function for the current group
  always_comb begin
    case (cmd.round[5:4])
      GRP_F:   f_val = (wb & wc) | (~wb & wd);
      GRP_G:   f_val = (wb & wd) | (wc & ~wd);
      GRP_H:   f_val = wb ^ wc ^ wd;
      default: f_val = wc ^ (wb | ~wd);
    endcase
  end

  assign rot_idx = {cmd.round[5:4], cmd.round[1:0]};
  assign rot_s   = ROT_S[rot_idx];
  assign t_sum   = wa + f_val + w_q + SINE_K[cmd.round];
  assign t_rot   = {t_sum, t_sum} << rot_s;

  // Working words: load, step one round per cycle
  always_ff @(posedge clk) begin
    if (cmd.work_load) begin
      wa <= chain_a;
      wb <= chain_b;
      wc <= chain_c;
      wd <= chain_d;
    end else if (cmd.round_en) begin
      wa <= wd;
      wd <= wc;
      wc <= wb;
      wb <= wb + t_rot[63:32];
    end
  end

  // Chaining words: fold in the block result, restart after a digest
  always_ff @(posedge clk) begin
    if (rst || cmd.chain_init) begin
      chain_a <= CHAIN_INIT_A;
      chain_b <= CHAIN_INIT_B;
      chain_c <= CHAIN_INIT_C;
      chain_d <= CHAIN_INIT_D;
    end else if (cmd.fold) begin
      chain_a <= chain_a + wa;
      chain_b <= chain_b + wb;
      chain_c <= chain_c + wc;
      chain_d <= chain_d + wd;
    end
  end

  // Output register: hold a word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      digest_half <= cmd.out_half ? {chain_d, chain_c} : {chain_b, chain_a};
      half_index  <= cmd.out_half;
      digest_done <= cmd.out_half;
    end
  end

endmodule

`default_nettype wire

// File: hdl/md5_message_digest_top.sv
// Top level of the MD5 digest block: controller plus datapath.
//
// Input channel: one message byte per word (data_byte), last_byte set on the
// final byte of a message; taken when in_valid and in_ready are both high.
// Output channel: two words per message, digest bytes 0..7 (half_index 0)
// then bytes 8..15 (half_index 1, digest_done 1), first byte in bits 7..0.
// A byte that does not close a 64-byte block leaves in_ready high unless it
// is the final byte. The 64th byte of a block starts a compression (one read
// setup, 64 rounds at one round per cycle through a single round unit, one
// fold), during which in_ready is low.
// The final byte adds a padding sweep of one byte per cycle up to the end
// of the block, one compression (two when the 8-byte length does not fit
// after the data), then the two digest words are loaded in turn, each once
// the output register is free.
// A stalled receiver holds the digest words in the output register; the
// next message is taken once the second word is in that register.
// Reset (rst, synchronous) restores the initial chaining words, clears the
// bit count and empties the output register.
`default_nettype none

module md5_message_digest_top
  import md5_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [63:0] digest_half,
  output      logic        half_index,
  output      logic        digest_done
);

  md5_cmd_t  cmd;
  md5_stat_t stat;

  md5_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_byte (last_byte),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  md5_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .data_byte   (data_byte),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_half (digest_half),
    .half_index  (half_index),
    .digest_done (digest_done)
  );

endmodule

`default_nettype wire

// File: hdl/md5_chk.sv
// Port-level checks for the MD5 digest block, bound to the top level.
`default_nettype none

module md5_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        last_byte,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] digest_half,
  input wire logic        half_index,
  input wire logic        digest_done
);

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(digest_half) && $stable(half_index))
    else $error("output word changed while stalled");

  // The second half follows the first as soon as it is taken
  a_half_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !half_index |=> out_valid && half_index)
    else $error("second digest half did not follow the first");

  // Done flag marks exactly the second half
  a_done_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (digest_done == half_index))
    else $error("digest_done does not match half_index");

  // No new byte while the first half waits
  a_no_intake: assert property (@(posedge clk) disable iff (rst)
    out_valid && !half_index |-> !in_ready)
    else $error("byte taken before digest was complete");

  // The final byte always drops in_ready, for padding or a compression
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_byte |=> !in_ready)
    else $error("block ready right after final byte");

endmodule

bind md5_message_digest_top md5_chk u_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .last_byte   (last_byte),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .digest_half (digest_half),
  .half_index  (half_index),
  .digest_done (digest_done)
);

`default_nettype wire

// File: sim/md5_message_digest_top_tb.sv
// Self-checking testbench for the MD5 digest block: random messages, digest scoreboard.
`timescale 1ns / 1ps

module md5_message_digest_top_tb;

  // MD5 per-round additive constants
  localparam logic [31:0] ROUND_CONST [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Left-rotate amounts, indexed by {round group, round mod 4}
  localparam int ROUND_SHIFT [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  // Message lengths around the block and padding boundaries
  localparam int EDGE_LEN [13] = '{1, 55, 56, 57, 63, 64, 65, 119, 120, 121, 127, 128, 129};

  localparam int RANDOM_BYTES = 1250;
  localparam int TAIL_CYCLES  = 250;

  typedef struct {
    logic [63:0] half;
    logic        idx;
    logic        done;
  } digest_word_t;

  // Track the running digest and check each output word against it
  class digest_scoreboard;
    logic [31:0]  chain [4];
    logic [7:0]   blk [64];
    logic [63:0]  bit_count;
    digest_word_t digest_q [$];
    int bytes_noted;
    int messages;
    int words_checked;
    int errors;

    function new();
      reset_chain();
      bit_count     = '0;
      bytes_noted   = 0;
      messages      = 0;
      words_checked = 0;
      errors        = 0;
    endfunction

    function void reset_chain();
      chain[0] = 32'h67452301;
      chain[1] = 32'hefcdab89;
      chain[2] = 32'h98badcfe;
      chain[3] = 32'h10325476;
    endfunction

    function logic [31:0] rotl(logic [31:0] v, int s);
      return (v << s) | (v >> (32 - s));
    endfunction

    // Run the 64-round compression over the current block
    function void mix_block();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, f, t;
      int g;
      for (int i = 0; i < 16; i++) begin
        w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
      end
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      for (int r = 0; r < 64; r++) begin
        case (r / 16)
          0: begin
            f = (b & c) | (~b & d);
            g = r;
          end
          1: begin
            f = (b & d) | (c & ~d);
            g = (5 * r + 1) % 16;
          end
          2: begin
            f = b ^ c ^ d;
            g = (3 * r + 5) % 16;
          end
          default: begin
            f = c ^ (b | ~d);
            g = (7 * r) % 16;
          end
        endcase
        t = a + f + w[g] + ROUND_CONST[r];
        a = d;
        d = c;
        c = b;
        b = b + rotl(t, ROUND_SHIFT[(r / 16) * 4 + r % 4]);
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
    endfunction

    // Store an accepted byte; on the final byte pad, finish and queue both digest words
    function void note_byte(logic [7:0] b, logic is_last);
      int pos;
      pos = int'(bit_count[8:3]);
      blk[pos] = b;
      bit_count += 64'd8;
      bytes_noted++;
      pos = (pos + 1) % 64;
      if (pos == 0) mix_block();
      if (!is_last) return;
      blk[pos] = 8'h80;
      for (int k = pos + 1; k < 64; k++) blk[k] = 8'h00;
      // length does not fit behind the marker: spill into an extra block
      if (pos >= 56) begin
        mix_block();
        foreach (blk[k]) blk[k] = 8'h00;
      end
      for (int k = 0; k < 8; k++) blk[56+k] = bit_count[8*k +: 8];
      mix_block();
      digest_q.push_back('{half: {chain[1], chain[0]}, idx: 1'b0, done: 1'b0});
      digest_q.push_back('{half: {chain[3], chain[2]}, idx: 1'b1, done: 1'b1});
      reset_chain();
      bit_count = '0;
      messages++;
    endfunction

    function int pending();
      return digest_q.size();
    endfunction

    // Compare one accepted output word with the oldest queued digest word
    function void check_word(logic [63:0] dh, logic hi, logic dd);
      digest_word_t want;
      if (digest_q.size() == 0) begin
        $error("digest word %h arrived with no digest pending", dh);
        errors++;
        return;
      end
      want = digest_q.pop_front();
      words_checked++;
      if (dh !== want.half) begin
        $error("digest_half mismatch: expected %h, actual %h", want.half, dh);
        errors++;
      end
      if (hi !== want.idx) begin
        $error("half_index mismatch: expected %0b, actual %0b", want.idx, hi);
        errors++;
      end
      if (dd !== want.done) begin
        $error("digest_done mismatch: expected %0b, actual %0b", want.done, dd);
        errors++;
      end
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [63:0] digest_half;
  logic        half_index;
  logic        digest_done;

  digest_scoreboard board = new();
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int longest_msg = 0;

  md5_message_digest_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_half (digest_half),
    .half_index  (half_index),
    .digest_done (digest_done)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Offer one byte after a random gap and hold it until the word is taken
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= is_last;
    do @(posedge clk); while (!in_ready);
    board.note_byte(b, is_last);
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == len - 1);
    end
    if (len > longest_msg) longest_msg = len;
  endtask

  // Drop valid and hold off until every queued digest word has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Accept output words, with a random stall before each while not in steady mode
  initial begin
    int stall;
    wait (rst == 1'b0);
    forever begin
      if ($urandom_range(0, 7) == 0) rx_steady = !rx_steady;
      stall = rx_steady ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      board.check_word(digest_half, half_index, digest_done);
    end
  end

  // Stimulus
  initial begin
    int len;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // single-byte messages at both byte extremes, then a short text message
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte("a", 1'b0);
    send_byte("b", 1'b0);
    send_byte("c", 1'b1);
    drain();
    // alternating bit patterns, back to back
    tx_steady = 1'b1;
    for (int i = 0; i < 20; i++) begin
      send_byte(i[0] ? 8'h55 : 8'haa, i == 19);
    end
    tx_steady = 1'b0;
    drain();

    // random messages, biased toward block and padding boundaries
    while (board.bytes_noted < RANDOM_BYTES) begin
      if ($urandom_range(0, 9) < 4) len = EDGE_LEN[$urandom_range(0, 12)];
      else len = $urandom_range(1, 70);
      tx_steady = ($urandom_range(0, 3) == 0);
      send_message(len);
      if ($urandom_range(0, 5) == 0) drain();
    end
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d message bytes in %0d messages, longest %0d bytes",
             board.bytes_noted, board.messages, longest_msg);
    $display("Checked %0d digest words, %0d mismatches", board.words_checked, board.errors);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Timeout: digest output stalled, %0d words pending", board.pending());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: filelist.f
hdl/md5_pkg.sv
hdl/md5_ctrl.sv
hdl/md5_dp.sv
hdl/md5_message_digest_top.sv
hdl/md5_chk.sv
sim/md5_message_digest_top_tb.sv
